[src/bitmap_id_allocator_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap ID allocator
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BIA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BIA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bia_pkg.sv]
// ---------------------------------------------------------------------------
// Bitmap ID allocator package
// Widths, codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package bia_pkg;

   localparam int MAP_BITS_DEF = 4096;
   localparam int NUM_W        = 13;
   localparam int STATUS_W     = 2;
   localparam int WORD_W       = 64;
   localparam int WORD_LOG     = 6;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd3;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic                capture;
      logic                rd_pref;
      logic                wr_pref;
      logic                rd_first;
      logic                rd_next;
      logic                wr_found;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                load_rsp;
      logic                clr_step;
   } dp_cmd_type;

   typedef struct packed {
      logic num_ok;
      logic act_free;
      logic pref_used;
      logic word_has_zero;
      logic at_last;
      logic rsp_free;
   } dp_sts_type;

endpackage

[src/bitmap_id_allocator_top.sv]
// ---------------------------------------------------------------------------
// Bitmap ID allocator
// Used-bit map of numbered objects with allocate and free requests.
// ---------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_action, req_object_number
//   rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_granted_number
//
// A request is settled by the preferred bit, or, when an allocate finds that
// bit taken, by a scan of the map words, one 64-bit word per cycle
// through the registered read port of the map RAM.
// After reset the map is cleared one word per cycle with req_stall high.
// A new request is taken while a previous result waits in the output register.
// ---------------------------------------------------------------------------
module bitmap_id_allocator_top import bia_pkg::*; #(
   parameter int MAP_BITS = MAP_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [NUM_W-1:0]    req_object_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [NUM_W-1:0]    rsp_granted_number
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bia_datapath #(
      .MAP_BITS (MAP_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_object_number  (req_object_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_number (rsp_granted_number)
   );

endmodule

[src/bia_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bia_datapath.sv]
// ---------------------------------------------------------------------------
// Bitmap ID allocator datapath
// Map memory, request capture, lowest-zero search and the result register.
// ---------------------------------------------------------------------------
module bia_datapath import bia_pkg::*; #(
   parameter int MAP_BITS = MAP_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   input  logic                req_action,
   input  logic [NUM_W-1:0]    req_object_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [NUM_W-1:0]    rsp_granted_number
);

   localparam int DEPTH     = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW        = ($clog2(MAP_BITS + 1) > NUM_W) ? $clog2(MAP_BITS + 1) : NUM_W;
   localparam int LAST_BITS = MAP_BITS - WORD_W * (DEPTH - 1);
   localparam int GW        = AW + WORD_LOG + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic                act_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [NUM_W-1:0]    grant_ff, grant_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [NUM_W-1:0]    rsp_granted_ff;

   logic [CW-1:0]       num_ext, idx;
   logic [AW-1:0]       pref_addr;
   logic [WORD_LOG-1:0] pref_bit;
   logic [WORD_W-1:0]   pref_onehot;
   logic [WORD_W-1:0]   rd_data, pad_mask, word_m, inv, lowest;
   logic [WORD_LOG-1:0] found_pos;
   logic [GW-1:0]       found_val;

   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr;
   logic [WORD_W-1:0]   wr_data;

   bia_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign num_ext     = CW'(num_ff);
   assign idx         = num_ext - CW'(1);
   assign pref_addr   = AW'(idx >> WORD_LOG);
   assign pref_bit    = idx[WORD_LOG-1:0];
   assign pref_onehot = WORD_W'(1) << pref_bit;

   // Bits past the end of the map read as taken
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         pad_mask[j] = (j >= LAST_BITS);
      end
   end

   assign word_m = (addr_ff == LAST_ADDR) ? (rd_data | pad_mask) : rd_data;
   assign inv    = ~word_m;
   assign lowest = inv & (~inv + WORD_W'(1));

   always_comb begin
      found_pos = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (lowest[j]) begin
            found_pos = found_pos | WORD_LOG'(j);
         end
      end
   end

   assign found_val = GW'({addr_ff, found_pos}) + GW'(1);

   assign rd_en = cmd.rd_pref | cmd.rd_first | cmd.rd_next;
   assign wr_en = cmd.clr_step | cmd.wr_pref | cmd.wr_found;

   always_comb begin
      rd_addr = addr_ff + AW'(1);
      if (cmd.rd_pref) begin
         rd_addr = pref_addr;
      end else if (cmd.rd_first) begin
         rd_addr = '0;
      end
   end

   always_comb begin
      wr_data = '0;
      if (cmd.wr_pref) begin
         wr_data = (act_ff == ACT_ALLOC) ? (rd_data | pref_onehot) : (rd_data & ~pref_onehot);
      end else if (cmd.wr_found) begin
         wr_data = rd_data | lowest;
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (rd_en) begin
         addr_in = rd_addr;
      end else if (cmd.clr_step) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      grant_in  = grant_ff;
      if (cmd.wr_pref) begin
         status_in = ST_OK;
         grant_in  = (act_ff == ACT_ALLOC) ? num_ff : '0;
      end else if (cmd.wr_found) begin
         status_in = ST_OK;
         grant_in  = NUM_W'(found_val);
      end else if (cmd.set_status) begin
         status_in = cmd.status_code;
         grant_in  = '0;
      end
   end

   // Hold the result until the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         num_ff <= req_object_number;
      end
      status_ff <= status_in;
      grant_ff  <= grant_in;
      if (cmd.load_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_granted_ff <= grant_ff;
      end
   end

   assign sts.num_ok        = (num_ext != '0) && (num_ext <= CW'(MAP_BITS));
   assign sts.act_free      = (act_ff == ACT_FREE);
   assign sts.pref_used     = rd_data[pref_bit];
   assign sts.word_has_zero = |inv;
   assign sts.at_last       = (addr_ff == LAST_ADDR);
   assign sts.rsp_free      = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_number = rsp_granted_ff;

endmodule

[src/bia_ctrl.sv]
// ---------------------------------------------------------------------------
// Bitmap ID allocator controller
// Sequences map clearing, the preferred-bit check and the word scan.
// ---------------------------------------------------------------------------
module bia_ctrl import bia_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      CHECK,
      PREF,
      SCAN,
      DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.at_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CHECK;
            end
         end
         CHECK: begin
            if (!sts.num_ok) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_INVALID;
               state_in        = DONE;
            end else begin
               cmd.rd_pref = 1'b1;
               state_in    = PREF;
            end
         end
         PREF: begin
            if (sts.act_free) begin
               if (sts.pref_used) begin
                  cmd.wr_pref = 1'b1;
               end else begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_NOTALLOC;
               end
               state_in = DONE;
            end else if (!sts.pref_used) begin
               cmd.wr_pref = 1'b1;
               state_in    = DONE;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = SCAN;
            end
         end
         SCAN: begin
            // One word arrives per cycle; stop at the first with a clear bit or at the last
            if (sts.word_has_zero) begin
               cmd.wr_found = 1'b1;
               state_in     = DONE;
            end else if (sts.at_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOSPACE;
               state_in        = DONE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

endmodule

[src/bia_checker.sv]
// ---------------------------------------------------------------------------
// Bitmap ID allocator port checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`include "bitmap_id_allocator_top_assert.svh"

module bia_checker import bia_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_action,
   input logic [NUM_W-1:0]    req_object_number,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [NUM_W-1:0]    rsp_granted_number
);

   // A stalled result must hold
   `BIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_number), "rsp changed while stalled")

   // Only a successful allocate grants a number
   `BIA_ASSERT_IMPLY(a_fail_no_grant, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_granted_number == '0, "number granted on a failed transaction")

   // One request at a time: the input closes after each accepted request
   `BIA_ASSERT_NEXT(a_req_closes, clock, reset, req_valid && !req_stall, req_stall, "request accepted back to back")

endmodule

bind bitmap_id_allocator_top bia_checker u_bia_checker (.*);
